// ===== rtl/gaussian_blur_3x3_tile_defines.svh =====
// Assertion macros shared by the blur tile RTL.
`ifndef GAUSSIAN_BLUR_3X3_TILE_DEFINES_SVH
`define GAUSSIAN_BLUR_3X3_TILE_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define GB3T_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define GB3T_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/gb3t_pkg.sv =====
// Shared types and constants for the 3x3 blur tile.
package gb3t_pkg;

	// Default tile geometry
	localparam int TILE_WIDTH_DEF  = 8;
	localparam int TILE_HEIGHT_DEF = 8;

	// Datapath widths
	localparam int PIX_W      = 8;
	localparam int COL_SUM_W  = 10;
	localparam int BLUR_SUM_W = 12;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_LOAD,
		ST_RUN,
		ST_FETCH,
		ST_WAIT
	} gb3t_state_t;

endpackage

// ===== rtl/gb3t_pix_if.sv =====
// Input pixel channel: valid/ready with one pixel per word.
interface gb3t_pix_if;
	import gb3t_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);

endinterface

// ===== rtl/gb3t_res_if.sv =====
// Result channel: valid/ready with one blurred pixel and a last mark per word.
interface gb3t_res_if;
	import gb3t_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic             last_out;

	modport source (output valid, output pixel_out, output last_out, input ready);
	modport sink (input valid, input pixel_out, input last_out, output ready);

endinterface

// ===== rtl/gb3t_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module gb3t_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/gaussian_blur_3x3_tile.sv =====
// Top level: 3x3 Gaussian blur over one tile held in a pixel RAM.
//
// Usage:
//   pixels  - input channel, one 8-bit pixel per word, raster order. A tile is
//             TILE_WIDTH*TILE_HEIGHT words; ready is high only while loading.
//   results - output channel, one blurred pixel per word in raster order,
//             border pixels zero, last_out set on the final word of a tile.
// Operation:
//   Ready stays high while loading, so every offered pixel is taken without
//   waiting. After the last pixel of a tile is taken the sequencer enters its
//   run state, which registers each result into the output register. A border
//   result is emitted directly; an inner result first reads one new column of
//   three pixels through the RAM's single read port, and the first inner result
//   of each row also reads its two leading columns first.
//   The next tile is accepted once the last result has entered the output
//   register.
// Reset: arst_n clears the sequencer and the output valid; the RAM contents
//   are not cleared, every entry is written before it is read.
// Stall: a held-off result waits in the output register and the sequencer
//   pauses before emitting the next result until it is taken.
module gaussian_blur_3x3_tile #(
	parameter int TILE_WIDTH  = gb3t_pkg::TILE_WIDTH_DEF,
	parameter int TILE_HEIGHT = gb3t_pkg::TILE_HEIGHT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	gb3t_pix_if.sink  pixels,
	gb3t_res_if.source results
);
	import gb3t_pkg::*;

	`include "gaussian_blur_3x3_tile_defines.svh"

	localparam int PIX = TILE_WIDTH * TILE_HEIGHT;
	localparam int AW  = $clog2(PIX);
	localparam int RW  = $clog2(TILE_HEIGHT);
	localparam int CW  = $clog2(TILE_WIDTH);
	localparam int FW  = $clog2(TILE_WIDTH + 2);
	localparam logic [1:0] TAP_LAST = 2'd2;

	// Registers
	gb3t_state_t            state_q, state_nxt;
	logic [AW-1:0]          load_cnt_q;
	logic [RW-1:0]          row_q;
	logic [CW-1:0]          col_q;
	logic [FW-1:0]          fcol_q;
	logic [AW-1:0]          rowbase_q;
	logic [1:0]             tap_q;
	logic                   rd_valid_s1;
	logic [1:0]             rd_tap_s1;
	logic [COL_SUM_W-1:0]   acc_q;
	logic [COL_SUM_W-1:0]   v0_q, v1_q, v2_q;
	logic                   out_valid_q;
	logic [PIX_W-1:0]       pixel_q;
	logic                   last_q;

	// Combinational signals
	logic                   accept_in;
	logic                   out_free;
	logic                   is_border;
	logic                   tile_end;
	logic                   window_full;
	logic [FW-1:0]          col_p2;
	logic                   emit;
	logic                   rd_en;
	logic [AW-1:0]          tap_off;
	logic [AW-1:0]          rd_addr;
	logic [PIX_W-1:0]       rd_data;
	logic [COL_SUM_W-1:0]   acc_nxt;
	logic                   col_done;
	logic [BLUR_SUM_W-1:0]  blur_sum;

	assign accept_in     = pixels.valid && pixels.ready;
	assign pixels.ready  = (state_q == ST_LOAD);
	assign out_free      = !out_valid_q || results.ready;

	assign results.valid     = out_valid_q;
	assign results.pixel_out = pixel_q;
	assign results.last_out  = last_q;

	// Classify the current output position
	assign is_border = (row_q == '0) || (row_q == RW'(TILE_HEIGHT - 1)) ||
		(col_q == '0) || (col_q == CW'(TILE_WIDTH - 1));
	assign tile_end  = (row_q == RW'(TILE_HEIGHT - 1)) && (col_q == CW'(TILE_WIDTH - 1));
	assign col_p2      = FW'(col_q) + FW'(2);
	assign window_full = (fcol_q == col_p2);

	// Address of the pixel above, at, or below the current row in the fetch column
	always_comb begin
		case (tap_q)
			2'd0:    tap_off = '0;
			2'd1:    tap_off = AW'(TILE_WIDTH);
			default: tap_off = AW'(2 * TILE_WIDTH);
		endcase
	end
	assign rd_addr = rowbase_q - AW'(TILE_WIDTH) + tap_off + AW'(fcol_q);

	// Vertical 1-2-1 accumulation of returning pixels
	always_comb begin
		logic [COL_SUM_W-1:0] base;
		logic [COL_SUM_W-1:0] term;
		base = (rd_tap_s1 == 2'd0) ? '0 : acc_q;
		term = (rd_tap_s1 == 2'd1) ? {1'b0, rd_data, 1'b0} : {2'b00, rd_data};
		acc_nxt = base + term;
	end
	assign col_done = rd_valid_s1 && (rd_tap_s1 == TAP_LAST);

	// Horizontal 1-2-1 over the column sums, then divide by 16
	assign blur_sum = {2'b00, v0_q} + {1'b0, v1_q, 1'b0} + {2'b00, v2_q};

	// Next state and sequencer strobes
	always_comb begin
		state_nxt = state_q;
		emit      = 1'b0;
		rd_en     = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				if (accept_in && (load_cnt_q == AW'(PIX - 1))) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				if (is_border || window_full) begin
					if (out_free) begin
						emit = 1'b1;
						if (tile_end) begin
							state_nxt = ST_LOAD;
						end
					end
				end else begin
					state_nxt = ST_FETCH;
				end
			end
			ST_FETCH: begin
				rd_en = 1'b1;
				if (tap_q == TAP_LAST) begin
					state_nxt = ST_WAIT;
				end
			end
			ST_WAIT: begin
				state_nxt = ST_RUN;
			end
			default: begin
				state_nxt = ST_LOAD;
			end
		endcase
	end

	// Hold the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Advance counters and control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q  <= '0;
			row_q       <= '0;
			col_q       <= '0;
			fcol_q      <= '0;
			rowbase_q   <= '0;
			tap_q       <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept_in) begin
				load_cnt_q <= (load_cnt_q == AW'(PIX - 1)) ? '0 : load_cnt_q + AW'(1);
			end
			if (rd_en) begin
				tap_q <= (tap_q == TAP_LAST) ? 2'd0 : tap_q + 2'd1;
			end
			rd_valid_s1 <= rd_en;
			if (col_done) begin
				fcol_q <= fcol_q + FW'(1);
			end
			if (emit) begin
				if (col_q == CW'(TILE_WIDTH - 1)) begin
					col_q  <= '0;
					fcol_q <= '0;
					if (row_q == RW'(TILE_HEIGHT - 1)) begin
						row_q     <= '0;
						rowbase_q <= '0;
					end else begin
						row_q     <= row_q + RW'(1);
						rowbase_q <= rowbase_q + AW'(TILE_WIDTH);
					end
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold datapath registers
	always_ff @(posedge clk) begin
		rd_tap_s1 <= tap_q;
		if (rd_valid_s1) begin
			acc_q <= acc_nxt;
		end
		if (col_done) begin
			v0_q <= v1_q;
			v1_q <= v2_q;
			v2_q <= acc_nxt;
		end
		if (emit) begin
			pixel_q <= is_border ? '0 : blur_sum[BLUR_SUM_W-1:4];
			last_q  <= tile_end;
		end
	end

	// Pixel store
	gb3t_ram #(
		.WIDTH(PIX_W),
		.DEPTH(PIX)
	) u_store (
		.clk   (clk),
		.we    (accept_in),
		.waddr (load_cnt_q),
		.wdata (pixels.pixel_in),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Assertions
	`GB3T_ASSERT_NOW(a_last_is_border, results.valid && results.last_out, results.pixel_out == '0, "last word of a tile must be a zero border pixel")
	`GB3T_ASSERT_NEXT(a_tile_starts_run, accept_in && (load_cnt_q == AW'(PIX - 1)), (state_q == ST_RUN) && (row_q == '0) && (col_q == '0), "full tile must start emission at the first pixel")
	`GB3T_ASSERT_NOW(a_wait_gets_last_tap, state_q == ST_WAIT, rd_valid_s1 && (rd_tap_s1 == TAP_LAST), "column wait without the last tap returning")

endmodule

// ===== verif/tb_gaussian_blur_3x3_tile.sv =====
// Testbench for gaussian_blur_3x3_tile: tiles in, blurred pixels checked against a local model.
`timescale 1ns / 1ps

module tb_gaussian_blur_3x3_tile;
	import gb3t_pkg::*;

	localparam int TW          = TILE_WIDTH_DEF;
	localparam int TH          = TILE_HEIGHT_DEF;
	localparam int TILE_PIXELS = TW * TH;
	localparam int IDLE_PCT    = 32;
	localparam int HOLD_CYCLES = 700;
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             last;
	} blur_word_t;

	typedef enum int {
		MIX_UNIFORM,
		MIX_SMOOTH,
		MIX_BRIGHT,
		MIX_SPARSE
	} tile_mix_t;

	logic clk;
	logic arst_n;

	gb3t_pix_if pix_if ();
	gb3t_res_if res_if ();

	gaussian_blur_3x3_tile #(
		.TILE_WIDTH  (TW),
		.TILE_HEIGHT (TH)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixels  (pix_if),
		.results (res_if)
	);

	// Local copy of the tile and the blurred words still owed by the block
	logic [PIX_W-1:0] tile_store [TILE_PIXELS];
	int               tile_fill;
	blur_word_t       expected_blur [$];
	blur_word_t       got_word;
	blur_word_t       want_word;
	int               mismatch_count;
	bit               idle_on;
	bit               rx_hold;

	// Clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// Store one accepted pixel; on a full tile, queue all 64 blurred words
	task automatic predict_blur(input logic [PIX_W-1:0] pix);
		int         acc;
		blur_word_t w;
		tile_store[tile_fill] = pix;
		tile_fill++;
		if (tile_fill == TILE_PIXELS) begin
			tile_fill = 0;
			for (int r = 0; r < TH; r++) begin
				for (int c = 0; c < TW; c++) begin
					acc = 0;
					if (r == 0 || c == 0 || r == TH - 1 || c == TW - 1) begin
						w.pixel = '0;
					end else begin
						for (int dr = -1; dr <= 1; dr++)
							for (int dc = -1; dc <= 1; dc++)
								acc += int'(tile_store[(r + dr) * TW + c + dc]) *
									((dr == 0) ? 2 : 1) * ((dc == 0) ? 2 : 1);
						w.pixel = PIX_W'(acc / 16);
					end
					w.last = (r == TH - 1) && (c == TW - 1);
					expected_blur.push_back(w);
				end
			end
		end
	endtask

	// Offer one pixel, with an optional gap first, and hold until it is taken
	task automatic send_pixel(input logic [PIX_W-1:0] pix);
		if (idle_on && $urandom_range(0, 99) < 25) begin
			pix_if.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		pix_if.valid    <= 1'b1;
		pix_if.pixel_in <= pix;
		do @(posedge clk); while (pix_if.ready !== 1'b1);
		predict_blur(pix);
	endtask

	// Hold the result channel off for as long as the cycles argument says
	task automatic hold_results(input int cycles);
		rx_hold = 1'b1;
		repeat (cycles) @(posedge clk);
		rx_hold = 1'b0;
	endtask

	function automatic logic [PIX_W-1:0] pick_pixel(input tile_mix_t mix,
			input logic [PIX_W-1:0] base);
		case (mix)
			MIX_UNIFORM: begin
				return PIX_W'($urandom_range(0, 255));
			end
			MIX_SMOOTH: begin
				return PIX_W'(int'(base) * 3 / 4 + $urandom_range(0, 63));
			end
			MIX_BRIGHT: begin
				return PIX_W'($urandom_range(200, 255));
			end
			default: begin
				return ($urandom_range(0, 9) == 0) ? PIX_W'($urandom_range(128, 255)) : '0;
			end
		endcase
	endfunction

	task automatic send_random_tile(input tile_mix_t mix);
		logic [PIX_W-1:0] base;
		base = PIX_W'($urandom_range(0, 255));
		for (int i = 0; i < TILE_PIXELS; i++)
			send_pixel(pick_pixel(mix, base));
	endtask

	// Every inner window at full scale: largest possible result
	task automatic test_saturated_tile();
		idle_on = 1'b0;
		for (int i = 0; i < TILE_PIXELS; i++)
			send_pixel(8'hFF);
	endtask

	// Checkerboard, a lone bright pixel, and small values that truncate
	task automatic test_pattern_tile();
		logic [PIX_W-1:0] pix;
		idle_on = 1'b1;
		for (int r = 0; r < TH; r++) begin
			for (int c = 0; c < TW; c++) begin
				if (r < 3)
					pix = ((r + c) % 2 == 1) ? 8'hFF : 8'h00;
				else if (r == 3)
					pix = (c == TW / 2) ? 8'hFF : 8'h00;
				else if (r < 6)
					pix = 8'h01;
				else
					pix = (c % 2 == 1) ? 8'h0F : 8'h11;
				send_pixel(pix);
			end
		end
	endtask

	// Block the results while two tiles are offered, so the input stalls
	task automatic test_backpressure();
		idle_on = 1'b1;
		fork
			hold_results(HOLD_CYCLES);
		join_none
		send_random_tile(MIX_UNIFORM);
		send_random_tile(MIX_SMOOTH);
	endtask

	// Random tiles of mixed content, one of them with no idling at all
	task automatic test_random_tiles();
		for (int t = 0; t < 3; t++) begin
			idle_on = (t != 2);
			send_random_tile(tile_mix_t'($urandom_range(0, 3)));
		end
		idle_on = 1'b1;
	endtask

	// Result ready: random idling, or held off on request
	always @(posedge clk) begin
		if (!arst_n || rx_hold)
			res_if.ready <= 1'b0;
		else if (!idle_on)
			res_if.ready <= 1'b1;
		else
			res_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Compare each accepted result with the oldest expected word
	always @(posedge clk) begin
		if (arst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			if (expected_blur.size() == 0) begin
				report_mismatch($sformatf("unexpected word pixel=%0d last=%0b",
					res_if.pixel_out, res_if.last_out));
			end else begin
				want_word = expected_blur.pop_front();
				got_word  = '{pixel: res_if.pixel_out, last: res_if.last_out};
				if (got_word.pixel !== want_word.pixel)
					report_mismatch($sformatf("pixel_out %0d, want %0d",
						got_word.pixel, want_word.pixel));
				if (got_word.last !== want_word.last)
					report_mismatch($sformatf("last_out %0b, want %0b",
						got_word.last, want_word.last));
			end
		end
	end

	// Main sequence
	initial begin
		arst_n          = 1'b0;
		pix_if.valid    = 1'b0;
		pix_if.pixel_in = '0;
		res_if.ready    = 1'b0;
		tile_fill       = 0;
		mismatch_count  = 0;
		idle_on         = 1'b1;
		rx_hold         = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_saturated_tile();
		test_pattern_tile();
		test_backpressure();
		test_random_tiles();
		pix_if.valid <= 1'b0;

		// Drain, then allow for any stray word
		wait (expected_blur.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("** gaussian_blur_3x3_tile: PASSED **");
		else
			$display("** gaussian_blur_3x3_tile: FAILED **");
		$finish;
	end

	// Timeout
	initial begin
		#2_000_000;
		$display("** gaussian_blur_3x3_tile: FAILED **");
		$finish;
	end

endmodule
